// File: sv/sitda_pkg.sv
// Shared types and constants for the signed integer to decimal text block.
// No dependencies; imported by every module of the block.
package sitda_pkg;

  localparam int unsigned MagW      = 32;
  localparam int unsigned DigitW    = 4;
  localparam int unsigned NumDigits = 10;
  localparam int unsigned BcdW      = DigitW * NumDigits;
  localparam int unsigned CharW     = 6;

  localparam logic [CharW-1:0]  CharZero  = 6'd48;
  localparam logic [CharW-1:0]  CharMinus = 6'd45;
  localparam logic [DigitW-1:0] AdjLimit  = 4'd5;
  localparam logic [DigitW-1:0] AdjAdd    = 4'd3;

  // Finished conversion handed from the converter to the character sequencer.
  typedef struct packed {
    logic            valid;
    logic            neg;
    logic [BcdW-1:0] bcd;
  } conv_t;

endpackage

// File: sv/signed_int_to_decimal_ascii.sv
// Top level: signed 32-bit integer to decimal ASCII characters.
// Depends on sitda_pkg, sitda_dabble and sitda_emit.
//
//   channel | handshake               | payload
//   --------+-------------------------+--------------------------
//   in      | in_valid_i / in_stall_o | value_i (32 bit signed)
//   out     | out_valid_o/out_stall_i | character_o (6), last_o
//
// After a transfer in, the converter makes 32 shift-add-3 passes, one a cycle,
// then the sequencer skips leading zeros at one digit a cycle and sends one
// character a cycle while out_stall_i is low; a new value is taken once the
// final character is loaded.
// Reset clears all control state; out_stall_i holds the current character and
// pauses the sequencer, while in_stall_o stays high until it moves on.
module signed_int_to_decimal_ascii (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic signed [31:0]          value_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [sitda_pkg::CharW-1:0] character_o,
  output logic                        last_o
);
  import sitda_pkg::*;

  logic            accept;
  logic            neg;
  logic [MagW-1:0] mag;
  logic            dab_busy;
  logic            emit_busy;
  conv_t           conv;

  assign neg    = value_i[MagW-1];
  // Two's complement negation; the most negative value gives 2^31 unsigned.
  assign mag    = neg ? (~MagW'(value_i) + 1'b1) : MagW'(value_i);

  assign in_stall_o = dab_busy | emit_busy;
  assign accept     = in_valid_i & ~in_stall_o;

  sitda_dabble u_dabble (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (accept),
    .neg_i    (neg),
    .mag_i    (mag),
    .busy_o   (dab_busy),
    .result_o (conv)
  );

  sitda_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .conv_i      (conv),
    .busy_o      (emit_busy),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .character_o (character_o),
    .last_o      (last_o)
  );

endmodule

// File: sv/sitda_dabble.sv
// Iterative binary to BCD converter: one shift-add-3 pass per cycle.
// Depends on sitda_pkg.
module sitda_dabble (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic                        neg_i,
  input  logic [sitda_pkg::MagW-1:0]  mag_i,
  output logic                        busy_o,
  output sitda_pkg::conv_t            result_o
);
  import sitda_pkg::*;

  localparam int unsigned CntW = $clog2(MagW);

  logic [MagW-1:0] shift_q, shift_d;
  logic [BcdW-1:0] bcd_q, bcd_d, adj;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic            neg_q, neg_d;

  // Each BCD digit of five or more gets three added before the shift.
  always_comb begin
    for (int i = 0; i < NumDigits; i++) begin
      if (bcd_q[i*DigitW +: DigitW] >= AdjLimit) begin
        adj[i*DigitW +: DigitW] = bcd_q[i*DigitW +: DigitW] + AdjAdd;
      end else begin
        adj[i*DigitW +: DigitW] = bcd_q[i*DigitW +: DigitW];
      end
    end
  end

  always_comb begin
    shift_d = shift_q;
    bcd_d   = bcd_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    neg_d   = neg_q;
    done_d  = 1'b0;
    if (start_i) begin
      shift_d = mag_i;
      bcd_d   = '0;
      cnt_d   = '0;
      busy_d  = 1'b1;
      neg_d   = neg_i;
    end else if (busy_q) begin
      bcd_d   = {adj[BcdW-2:0], shift_q[MagW-1]};
      shift_d = {shift_q[MagW-2:0], 1'b0};
      cnt_d   = cnt_q + 1'b1;
      if (cnt_q == CntW'(MagW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shift_q <= shift_d;
    bcd_q   <= bcd_d;
    neg_q   <= neg_d;
  end

  assign busy_o         = busy_q | done_q;
  assign result_o.valid = done_q;
  assign result_o.neg   = neg_q;
  assign result_o.bcd   = bcd_q;

  a_start_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q && !done_q)
    else $error("conversion started while one was in progress");

  a_done_after_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q) && $past(cnt_q) == CntW'(MagW - 1))
    else $error("conversion finished without a full set of passes");

  a_start_begins : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> busy_q && cnt_q == '0)
    else $error("conversion did not begin after start");

endmodule

// File: sv/sitda_emit.sv
// Character sequencer: skips leading zero digits, then sends the sign and
// digits one transfer at a time through an output register. Depends on sitda_pkg.
module sitda_emit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  sitda_pkg::conv_t            conv_i,
  output logic                        busy_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [sitda_pkg::CharW-1:0] character_o,
  output logic                        last_o
);
  import sitda_pkg::*;

  localparam int unsigned LeftW = $clog2(NumDigits + 1);

  typedef enum logic [1:0] {
    E_IDLE,
    E_SKIP,
    E_OUT
  } emit_state_e;

  emit_state_e       state_q;
  logic [BcdW-1:0]   digits_q;
  logic [LeftW-1:0]  left_q;
  logic              neg_q;
  logic              valid_q;
  logic [CharW-1:0]  char_q;
  logic              last_q;
  logic [DigitW-1:0] top_digit;
  logic              load_char;

  assign top_digit = digits_q[BcdW-1 -: DigitW];
  // A new character goes into the output register when it is empty or its
  // transfer completes at this edge.
  assign load_char = (state_q == E_OUT) && (!valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= E_IDLE;
      digits_q <= '0;
      left_q   <= '0;
      neg_q    <= 1'b0;
      valid_q  <= 1'b0;
      char_q   <= '0;
      last_q   <= 1'b0;
    end else begin
      if (load_char) begin
        valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        valid_q <= 1'b0;
      end
      case (state_q)
        E_IDLE: begin
          if (conv_i.valid) begin
            digits_q <= conv_i.bcd;
            left_q   <= LeftW'(NumDigits);
            neg_q    <= conv_i.neg;
            state_q  <= E_SKIP;
          end
        end
        E_SKIP: begin
          // The final digit is always sent, so a zero value still prints '0'.
          if (top_digit == '0 && left_q > LeftW'(1)) begin
            digits_q <= {digits_q[BcdW-DigitW-1:0], {DigitW{1'b0}}};
            left_q   <= left_q - 1'b1;
          end else begin
            state_q <= E_OUT;
          end
        end
        E_OUT: begin
          if (load_char) begin
            if (neg_q) begin
              char_q <= CharMinus;
              last_q <= 1'b0;
              neg_q  <= 1'b0;
            end else begin
              char_q   <= CharZero + CharW'(top_digit);
              last_q   <= (left_q == LeftW'(1));
              digits_q <= {digits_q[BcdW-DigitW-1:0], {DigitW{1'b0}}};
              left_q   <= left_q - 1'b1;
              if (left_q == LeftW'(1)) begin
                state_q <= E_IDLE;
              end
            end
          end
        end
        default: begin
          state_q <= E_IDLE;
        end
      endcase
    end
  end

  assign busy_o      = (state_q != E_IDLE);
  assign out_valid_o = valid_q;
  assign character_o = char_q;
  assign last_o      = last_q;

  a_load_when_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    conv_i.valid |-> state_q == E_IDLE)
    else $error("conversion result arrived while characters were being sent");

  a_left_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != E_IDLE |-> left_q != '0)
    else $error("digit count ran out before the last character");

  a_last_is_digit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && last_q |-> char_q != CharMinus)
    else $error("final character is not a digit");

endmodule

// File: bench/signed_int_to_decimal_ascii_test.sv
// Self-checking bench for signed_int_to_decimal_ascii: drives signed integers and checks
// each ASCII character of their decimal text against a scoreboard prediction.
// Depends on sitda_pkg and the signed_int_to_decimal_ascii RTL.
class decimal_text_scoreboard;
  typedef struct packed {
    logic [sitda_pkg::CharW-1:0] code;
    logic                        last;
  } text_char_t;

  localparam logic [31:0] DecimalBase = 32'd10;

  text_char_t  expected_chars[$];
  int unsigned errors;

  function new();
    errors = 0;
  endfunction

  // Queue the characters that one accepted value should produce.
  function void note_value(logic [31:0] raw);
    logic [31:0] mag;
    logic [3:0]  digit_buf[10];
    int          n_digits;
    text_char_t  ch;
    n_digits = 0;
    // The unsigned negation also handles the most negative value correctly.
    mag = raw[31] ? (32'd0 - raw) : raw;
    do begin
      digit_buf[n_digits] = 4'(mag % DecimalBase);
      mag = mag / DecimalBase;
      n_digits++;
    end while (mag != 0 && n_digits < 10);
    if (raw[31]) begin
      ch.code = sitda_pkg::CharMinus;
      ch.last = 1'b0;
      expected_chars.push_back(ch);
    end
    for (int i = n_digits - 1; i >= 0; i--) begin
      ch.code = sitda_pkg::CharZero + {2'b00, digit_buf[i]};
      ch.last = (i == 0);
      expected_chars.push_back(ch);
    end
  endfunction

  function void check_char(logic [sitda_pkg::CharW-1:0] code, logic last);
    text_char_t want;
    if (expected_chars.size() == 0) begin
      $display("%0t: unexpected character %0d last %0b", $time, code, last);
      errors++;
    end else begin
      want = expected_chars.pop_front();
      if (code !== want.code) begin
        $display("%0t: character expected %0d actual %0d", $time, want.code, code);
        errors++;
      end
      if (last !== want.last) begin
        $display("%0t: last flag expected %0b actual %0b", $time, want.last, last);
        errors++;
      end
    end
  endfunction

  function int unsigned outstanding();
    return expected_chars.size();
  endfunction
endclass

module signed_int_to_decimal_ascii_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit   = 400000;
  localparam int unsigned SettleCycles = 80;
  localparam int unsigned LongHold     = 400;

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        in_valid_i = 1'b0;
  logic                        in_stall_o;
  logic signed [31:0]          value_i = '0;
  logic                        out_valid_o;
  logic                        out_stall_i = 1'b0;
  logic [sitda_pkg::CharW-1:0] character_o;
  logic                        last_o;

  decimal_text_scoreboard text_sb = new();

  int unsigned cycle_count = 0;
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_requests = 0;

  signed_int_to_decimal_ascii uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .character_o (character_o),
    .last_o      (last_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  // Observe both channels at the edge; every transfer goes to the scoreboard.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        text_sb.note_value(value_i);
      end
      if (out_valid_o && !out_stall_i) begin
        text_sb.check_char(character_o, last_o);
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off counted here whenever one is requested.
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  always @(posedge clk_i) begin
    if (hold_requests != hold_seen) begin
      hold_seen = hold_requests;
      hold_left = LongHold;
    end
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  initial begin
    wait (cycle_count >= CycleLimit);
    $display("%0t: timeout with %0d characters outstanding", $time, text_sb.outstanding());
    $display("RESULT: ERROR");
    $finish;
  end

  // Called at a clock edge; returns at the edge where the value is transferred.
  task automatic send_value(input logic [31:0] v);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    value_i    <= v;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (text_sb.outstanding() != 0) @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_value();
    logic [31:0] span;
    logic [31:0] mag;
    int unsigned k;
    span = 32'd1;
    case ($urandom_range(0, 3))
      0: mag = $urandom();
      1: begin
        // A magnitude with exactly k digits.
        k = $urandom_range(1, 9);
        repeat (k) span = span * 32'd10;
        mag = $urandom_range(span / 32'd10, span - 32'd1);
      end
      2: mag = $urandom_range(0, 20);
      default: begin
        // Just either side of a power of ten, where the digit count changes.
        k = $urandom_range(0, 9);
        repeat (k) span = span * 32'd10;
        mag = span + $urandom_range(0, 2) - 32'd1;
      end
    endcase
    return $urandom_range(0, 1) ? (32'd0 - mag) : mag;
  endfunction

  logic [31:0] directed_values[] = '{
    32'd0, 32'd1, -32'sd1, 32'd9, 32'd10, -32'sd10, 32'd99, 32'd100, -32'sd5,
    32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'd1000000000, 32'd999999999,
    -32'sd999999999, 32'd1234567890, -32'sd1234567890, 32'h5555_5555,
    32'hAAAA_AAAA, 32'd1000, -32'sd1000000000, 32'hFFFF_FFF6
  };

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_values[i]) send_value(directed_values[i]);
    wait_drained();

    // Phases of idling: none, sender only, receiver only, both.
    for (int phase = 0; phase < 4; phase++) begin
      idle_pct  = (phase == 1) ? 55 : (phase == 3) ? 34 : 0;
      stall_pct = (phase == 2) ? 55 : (phase == 3) ? 34 : 0;
      repeat (45) send_value(pick_value());
      wait_drained();
    end

    // The receiver holds off while the sender keeps offering, so the block backs up.
    idle_pct  = 0;
    stall_pct = 0;
    hold_requests = hold_requests + 1;
    repeat (8) send_value(pick_value());
    wait_drained();

    repeat (SettleCycles) @(posedge clk_i);
    if (text_sb.outstanding() != 0) begin
      $display("%0t: %0d expected characters never arrived", $time, text_sb.outstanding());
    end
    if (text_sb.errors == 0 && text_sb.outstanding() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule

// File: sim.f
sv/sitda_pkg.sv
sv/sitda_dabble.sv
sv/sitda_emit.sv
sv/signed_int_to_decimal_ascii.sv
bench/signed_int_to_decimal_ascii_test.sv
